// ----- rtl/credible_level_finder_core_defines.svh -----
// Assertion macros for the credible level finder core.
`ifndef CREDIBLE_LEVEL_FINDER_CORE_DEFINES_SVH
`define CREDIBLE_LEVEL_FINDER_CORE_DEFINES_SVH

// Implication checked every clock, quiet during reset.
`define CLF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same check, but also active while reset is high.
`define CLF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/clf_pkg.sv -----
// Shared types and constants for the credible level finder.
`timescale 1ns / 1ps
package clf_pkg;

   localparam int NUM_LEVELS = 5;
   localparam int FRAC_BITS  = 16;
   localparam int LEVEL_BITS = 3;

   typedef logic [FRAC_BITS-1:0]  frac_type;
   typedef logic [LEVEL_BITS-1:0] level_type;

   localparam level_type LAST_LEVEL  = 3'd4;
   localparam level_type FIRST_LEVEL = 3'd0;

   localparam frac_type FRAC_RESET [NUM_LEVELS] =
      '{16'd44564, 16'd58982, 16'd62259, 16'd64880, 16'd65359};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_CHECK,
      ST_SCAN,
      ST_ACC,
      ST_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic      load;       // store and sum one input word
      logic      run_clear;  // end of run
      logic      prod;       // product of fraction sel and total
      logic      sel_init;   // start of selection
      logic      scan_init;
      logic      scan_step;
      logic      acc;        // add chosen bin to running sum
      logic      cmp;        // compare running sum against product sel
      level_type sel;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic scan_end;
   } status_type;

endpackage

// ----- rtl/credible_level_finder_core.sv -----
// Load one bin word per cycle; after the last bin, the five level products are formed, then per chosen bin
// a scan of all n loaded bins through the bin RAM read port, an accumulate step and the level compares.
// Five level words follow, one per cycle when not stalled. Input is stalled from the last bin
// until the fifth level word. Synchronous active-high reset restores the default fractions
// and empties the run; bin RAM contents are not cleared.
`timescale 1ns / 1ps
`include "credible_level_finder_core_defines.svh"
module credible_level_finder_core #(
   parameter int NUM_BINS    = 16384,
   parameter int WEIGHT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_bin_weight,
   input  logic        req_bin_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_level_index,
   output logic [31:0] rsp_level_weight,
   output logic        rsp_level_found,
   output logic        rsp_level_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import clf_pkg::*;

   frac_type   frac_ff [NUM_LEVELS];
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= FRAC_RESET;
      end else if (csr_write && (csr_index < LEVEL_BITS'(NUM_LEVELS))) begin
         frac_ff[csr_index] <= csr_data;
      end
   end

   clf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_bin_last   (req_bin_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level_last (rsp_level_last),
      .cmd            (cmd),
      .status         (status)
   );

   clf_dp #(.NUM_BINS(NUM_BINS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_bin_weight   (req_bin_weight),
      .frac             (frac_ff),
      .rsp_level_weight (rsp_level_weight),
      .rsp_level_found  (rsp_level_found)
   );

   assign rsp_level_index = cmd.sel;

   `CLF_ASSERT(a_no_load_during_emit, rsp_valid |-> req_stall, "input taken while emitting")
   `CLF_ASSERT(a_last_ends_run, rsp_valid && !rsp_stall && rsp_level_last |=> !rsp_valid, "extra level word")
   `CLF_ASSERT(a_last_on_top, rsp_valid |-> (rsp_level_last == (rsp_level_index == LAST_LEVEL)), "last flag misplaced")
   `CLF_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "word after reset")
endmodule

// ----- rtl/clf_ram.sv -----
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module clf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/clf_ctrl.sv -----
// Controller state machine: load, selection loop and level output.
`timescale 1ns / 1ps
module clf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_bin_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_level_last,
   output clf_pkg::cmd_type    cmd,
   input  clf_pkg::status_type status
);
   import clf_pkg::*;

   state_type state_ff, state_in;
   level_type sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         sel_ff   <= FIRST_LEVEL;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_bin_last) begin
                  state_in = ST_PREP;
                  sel_in   = FIRST_LEVEL;
               end
            end
         end
         ST_PREP: begin
            cmd.prod = 1'b1;
            if (sel_ff == LAST_LEVEL) begin
               cmd.sel_init = 1'b1;
               sel_in       = FIRST_LEVEL;
               state_in     = ST_CHECK;
            end else begin
               sel_in = sel_ff + 3'd1;
            end
         end
         ST_CHECK: begin
            sel_in = FIRST_LEVEL;
            if (status.stop) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_end) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            sel_in   = FIRST_LEVEL;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            if (sel_ff == LAST_LEVEL) begin
               sel_in   = FIRST_LEVEL;
               state_in = ST_CHECK;
            end else begin
               sel_in = sel_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sel_ff == LAST_LEVEL) begin
                  cmd.run_clear = 1'b1;
                  sel_in        = FIRST_LEVEL;
                  state_in      = ST_LOAD;
               end else begin
                  sel_in = sel_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_level_last = (sel_ff == LAST_LEVEL);
endmodule

// ----- rtl/clf_dp.sv -----
// Datapath: bin memory, totals, largest-bin scan, fraction compares, levels.
`timescale 1ns / 1ps
module clf_dp #(
   parameter int NUM_BINS    = 16384,
   parameter int WEIGHT_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  clf_pkg::cmd_type   cmd,
   output clf_pkg::status_type status,
   input  logic [31:0]        req_bin_weight,
   input  clf_pkg::frac_type  frac [clf_pkg::NUM_LEVELS],
   output logic [31:0]        rsp_level_weight,
   output logic               rsp_level_found
);
   import clf_pkg::*;

   localparam int SW = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
   localparam int CW = $clog2(NUM_BINS + 1);
   localparam int AW = $clog2(NUM_BINS);
   localparam int TW = SW + CW;
   localparam int PW = TW + FRAC_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] sum_ff, sum_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          stop_ff, stop_in;
   logic          gt_prev_ff, gt_prev_in;
   logic          have_prev_ff, have_prev_in;
   logic          best_ok_ff, best_ok_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          lvl_f_ff [NUM_LEVELS];
   logic          lvl_f_in [NUM_LEVELS];

   logic [PW-1:0] prod_ff [NUM_LEVELS];
   logic [PW-1:0] prod_in;
   logic [SW-1:0] lvl_w_ff [NUM_LEVELS];
   logic [SW-1:0] lvl_w_in [NUM_LEVELS];
   logic [SW-1:0] best_w_ff, best_w_in;
   logic [AW-1:0] best_i_ff, best_i_in;
   logic [SW-1:0] prev_w_ff, prev_w_in;
   logic [AW-1:0] prev_i_ff, prev_i_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;

   logic [SW-1:0] rd_data;
   logic [SW-1:0] wt;
   logic          wr_en;
   logic          eligible;
   logic [PW-1:0] lhs;
   logic          lt, gt;

   assign wt    = req_bin_weight[SW-1:0];
   assign wr_en = cmd.load && (count_ff < CW'(NUM_BINS));

   clf_ram #(.WIDTH(SW), .DEPTH(NUM_BINS)) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wt),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign eligible = !have_prev_ff || (rd_data < prev_w_ff) ||
                     ((rd_data == prev_w_ff) && (rd_idx_ff > prev_i_ff));
   assign lhs = {sum_ff, {FRAC_BITS{1'b0}}};
   assign lt  = lhs < prod_ff[cmd.sel];
   assign gt  = lhs > prod_ff[cmd.sel];

   always_comb begin
      count_in     = count_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      addr_in      = addr_ff;
      stop_in      = stop_ff;
      gt_prev_in   = gt_prev_ff;
      have_prev_in = have_prev_ff;
      best_ok_in   = best_ok_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_w_in    = best_w_ff;
      best_i_in    = best_i_ff;
      prev_w_in    = prev_w_ff;
      prev_i_in    = prev_i_ff;
      prod_in      = PW'(frac[cmd.sel]) * PW'(total_ff);
      lvl_f_in     = lvl_f_ff;
      lvl_w_in     = lvl_w_ff;

      if (wr_en) begin
         count_in = count_ff + CW'(1);
         total_in = total_ff + TW'(wt);
      end
      if (cmd.run_clear) begin
         count_in = '0;
         total_in = '0;
      end
      if (cmd.sel_init) begin
         sum_in       = '0;
         pos_in       = '0;
         have_prev_in = 1'b0;
         stop_in      = (total_ff == '0) || (frac[LAST_LEVEL] == '0);
         for (int k = 0; k < NUM_LEVELS; k++) begin
            lvl_f_in[k] = 1'b0;
            lvl_w_in[k] = '0;
         end
      end
      if (cmd.scan_init) begin
         addr_in    = '0;
         best_ok_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (addr_ff < count_ff) begin
            addr_in     = addr_ff + CW'(1);
            rd_valid_in = 1'b1;
            rd_idx_in   = addr_ff[AW-1:0];
         end
         if (rd_valid_ff && eligible && (!best_ok_ff || rd_data > best_w_ff)) begin
            best_ok_in = 1'b1;
            best_w_in  = rd_data;
            best_i_in  = rd_idx_ff;
         end
      end
      if (cmd.acc) begin
         sum_in       = sum_ff + TW'(best_w_ff);
         pos_in       = pos_ff + CW'(1);
         prev_w_in    = best_w_ff;
         prev_i_in    = best_i_ff;
         have_prev_in = 1'b1;
      end
      if (cmd.cmp) begin
         gt_prev_in = gt;
         if (lt && ((cmd.sel == FIRST_LEVEL) || gt_prev_ff)) begin
            lvl_f_in[cmd.sel] = 1'b1;
            lvl_w_in[cmd.sel] = best_w_ff;
         end
         if (cmd.sel == LAST_LEVEL) begin
            stop_in = !lt || (pos_ff == count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         addr_ff      <= '0;
         stop_ff      <= 1'b1;
         gt_prev_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         best_ok_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         for (int k = 0; k < NUM_LEVELS; k++) begin
            lvl_f_ff[k] <= 1'b0;
            lvl_w_ff[k] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         addr_ff      <= addr_in;
         stop_ff      <= stop_in;
         gt_prev_ff   <= gt_prev_in;
         have_prev_ff <= have_prev_in;
         best_ok_ff   <= best_ok_in;
         rd_valid_ff  <= rd_valid_in;
         lvl_f_ff     <= lvl_f_in;
         lvl_w_ff     <= lvl_w_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      best_w_ff <= best_w_in;
      best_i_ff <= best_i_in;
      prev_w_ff <= prev_w_in;
      prev_i_ff <= prev_i_in;
      if (cmd.prod) begin
         prod_ff[cmd.sel] <= prod_in;
      end
   end

   assign status.stop     = stop_ff;
   assign status.scan_end = (addr_ff == count_ff) && !rd_valid_ff;

   assign rsp_level_weight = 32'(lvl_w_ff[cmd.sel]);
   assign rsp_level_found  = lvl_f_ff[cmd.sel];
endmodule
